[rtl/core/assert_macros.svh]
// Assertion macros shared by the mixer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define RWDM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define RWDM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/rwdm_pkg.sv]
// Package: widths, constants and shared types of the ramped wet/dry mixer.
`timescale 1ns / 1ps
`default_nettype none
package rwdm_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int GAIN_W     = 32;            // Q4.28 running gain
  localparam int GOAL_W     = 16;            // Q4.12 target
  localparam int INC_W      = 33;            // signed Q4.28 step
  localparam int STEP_W     = 14;            // ramp countdown
  localparam int GAIN_SHIFT = 16;
  localparam int MIX_SHIFT  = 20;
  localparam int COEF_W     = GAIN_W - 8;    // gain truncated to Q4.20
  localparam int PROD_W     = SAMPLE_W + COEF_W + 1;
  localparam int ACC_W      = SAMPLE_W + 26;
  localparam int QUO_W      = 32;            // divider quotient / dividend
  localparam int QCNT_W     = $clog2(QUO_W);

  localparam logic [STEP_W-1:0] RAMP_RESET = STEP_W'(2400);

  // gain index
  localparam logic CH_WET = 1'b0;
  localparam logic CH_DRY = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  localparam sample_t SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_TAKE  = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_ADV   = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_DRAIN = 7'b0100000,
    S_FIN   = 7'b1000000
  } seq_state_t;

  typedef struct packed {
    logic clear;   // zero both accumulators
    logic issue;   // launch one product
    logic side;    // 0 = left accumulator, 1 = right
  } mac_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;    // one-cycle pulse, quotient valid
  } div_status_t;

endpackage
`default_nettype wire

[rtl/core/rwdm_if.sv]
// Channel interfaces: sample input, mixed output and ramp length write.
`timescale 1ns / 1ps
`default_nettype none
interface rwdm_in_if import rwdm_pkg::*; ();
  logic              valid;
  logic              ready;
  sample_t           in_left;
  sample_t           in_right;
  sample_t           wet_left;
  sample_t           wet_right;
  logic [GOAL_W-1:0] wet_target;
  logic [GOAL_W-1:0] dry_target;
  logic              block_start;
  logic              snap;

  modport source (output valid, in_left, in_right, wet_left, wet_right, wet_target,
                  dry_target, block_start, snap, input ready);
  modport sink   (input valid, in_left, in_right, wet_left, wet_right, wet_target,
                  dry_target, block_start, snap, output ready);
endinterface

interface rwdm_out_if import rwdm_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t out_left;
  sample_t out_right;

  modport source (output valid, out_left, out_right, input ready);
  modport sink   (input valid, out_left, out_right, output ready);
endinterface

interface rwdm_cfg_if import rwdm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STEP_W-1:0] ramp_steps;

  modport source (output valid, ramp_steps, input ready);
  modport sink   (input valid, ramp_steps, output ready);
endinterface
`default_nettype wire

[rtl/core/ramped_wet_dry_mixer.sv]
// Top level: ramped wet/dry stereo mixer with sequencer, gain state and output register.
//
// Channel     Modport  Transaction
// sample_in   sink     dry L/R, wet L/R, wet/dry targets, block_start, snap
// mix_out     source   out_left, out_right (saturated)
// cfg         sink     ramp_steps write (ready while idle)
//
// A sample is taken in IDLE; its result is registered after the states TAKE, ADV, MUL,
// DRAIN and FIN, and with snap TAKE settles both gains in a single pass.
// Each gain whose target changes at a block start (without snap) adds a pass through the serial
// divider (one quotient bit a cycle) before the sequencer goes on.
// The four products go one a cycle through the single multiplier.
// Reset (rst, synchronous) clears all gains, goals and steps and sets ramp_steps to 2400.
// A result waits in the output register; the next sample is taken meanwhile
// and the sequencer only holds at its last step if that register is still full and not being read.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ramped_wet_dry_mixer import rwdm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  rwdm_in_if.sink   sample_in,
  rwdm_out_if.source mix_out,
  rwdm_cfg_if.sink  cfg
);

  seq_state_t state;

  // config
  logic [STEP_W-1:0] ramp_steps;
  logic [STEP_W-1:0] ramp_n;

  // captured sample
  sample_t           dry_l, dry_r, wet_l, wet_r;
  logic [GOAL_W-1:0] tgt_wet, tgt_dry;
  logic              start_r, snap_r;

  // gain state, index CH_WET / CH_DRY
  logic [GAIN_W-1:0] gain_now       [2];
  logic [GOAL_W-1:0] gain_goal      [2];
  logic [INC_W-1:0]  gain_increment [2];
  logic [STEP_W-1:0] steps_left     [2];

  logic ch;        // gain under work in TAKE / DIV
  logic neg;       // sign of the pending ramp difference
  logic [1:0] mcnt;

  // TAKE datapath
  logic [GOAL_W-1:0] tgt_sel;
  logic [INC_W-1:0]  diff;
  logic [INC_W-1:0]  diff_neg;
  logic [QUO_W-1:0]  diff_mag;
  logic              restart;

  // shared units
  logic              div_start;
  div_status_t       div_st;
  logic [QUO_W-1:0]  quotient;
  logic [INC_W-1:0]  quo_ext;
  mac_ctrl_t         mac_ctrl;
  sample_t           mac_sample;
  logic [COEF_W-1:0] mac_coef;
  logic signed [ACC_W-1:0] acc_left, acc_right;

  // output register
  logic    out_vld;
  sample_t out_l, out_r;
  logic    out_free;

  // ------------------------------------------------------------------
  // Config: accepted and written only while idle
  // ------------------------------------------------------------------
  assign cfg.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_steps <= RAMP_RESET;
    end else if (cfg.valid && cfg.ready) begin
      ramp_steps <= cfg.ramp_steps;
    end
  end

  // zero-length ramp runs as one step
  assign ramp_n = (ramp_steps == '0) ? STEP_W'(1) : ramp_steps;

  // ------------------------------------------------------------------
  // Target take: difference (target<<16) - current, as sign and magnitude
  // ------------------------------------------------------------------
  assign tgt_sel  = (ch == CH_WET) ? tgt_wet : tgt_dry;
  assign diff     = {1'b0, tgt_sel, {GAIN_SHIFT{1'b0}}} - {1'b0, gain_now[ch]};
  assign diff_neg = -diff;
  assign diff_mag = diff[INC_W-1] ? diff_neg[QUO_W-1:0] : diff[QUO_W-1:0];
  assign restart  = start_r && (tgt_sel != gain_goal[ch]);
  assign div_start = (state == S_TAKE) && !snap_r && restart;

  // quotient truncates toward zero; reapply the sign
  assign quo_ext = neg ? -{1'b0, quotient} : {1'b0, quotient};

  rwdm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (diff_mag),
    .divisor  (ramp_n),
    .status   (div_st),
    .quotient (quotient)
  );

  // ------------------------------------------------------------------
  // Mix: products in order dryL*gd, wetL*gw, dryR*gd, wetR*gw
  // ------------------------------------------------------------------
  always_comb begin
    mac_ctrl.clear = (state == S_ADV);
    mac_ctrl.issue = (state == S_MUL);
    mac_ctrl.side  = mcnt[1];
    case (mcnt)
      2'd0:    begin mac_sample = dry_l; mac_coef = gain_now[CH_DRY][GAIN_W-1:8]; end
      2'd1:    begin mac_sample = wet_l; mac_coef = gain_now[CH_WET][GAIN_W-1:8]; end
      2'd2:    begin mac_sample = dry_r; mac_coef = gain_now[CH_DRY][GAIN_W-1:8]; end
      default: begin mac_sample = wet_r; mac_coef = gain_now[CH_WET][GAIN_W-1:8]; end
    endcase
  end

  rwdm_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (mac_ctrl),
    .sample    (mac_sample),
    .coef      (mac_coef),
    .acc_left  (acc_left),
    .acc_right (acc_right)
  );

  // round half up at bit 20, then clamp to the sample range
  function automatic sample_t round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] r;
    logic signed [ACC_W-1:0] q;
    logic [ACC_W-SAMPLE_W:0] top;
    sample_t res;
    r   = acc + ACC_W'(1 << (MIX_SHIFT - 1));
    q   = r >>> MIX_SHIFT;
    top = q[ACC_W-1:SAMPLE_W-1];
    if ((&top) || !(|top)) begin
      res = q[SAMPLE_W-1:0];
    end else begin
      res = q[ACC_W-1] ? SAT_MIN : SAT_MAX;
    end
    return res;
  endfunction

  // ------------------------------------------------------------------
  // Sequencer
  // ------------------------------------------------------------------
  assign sample_in.ready = (state == S_IDLE);
  assign out_free        = !out_vld || mix_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ch    <= CH_WET;
      mcnt  <= '0;
      neg   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (sample_in.valid) begin
            ch    <= CH_WET;
            state <= S_TAKE;
          end
        end
        S_TAKE: begin
          if (snap_r) begin
            state <= S_ADV;
          end else if (restart) begin
            neg   <= diff[INC_W-1];
            state <= S_DIV;
          end else if (ch == CH_DRY) begin
            state <= S_ADV;
          end else begin
            ch <= CH_DRY;
          end
        end
        S_DIV: begin
          if (div_st.done) begin
            if (ch == CH_DRY) begin
              state <= S_ADV;
            end else begin
              ch    <= CH_DRY;
              state <= S_TAKE;
            end
          end
        end
        S_ADV: begin
          mcnt  <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          mcnt <= mcnt + 1'b1;
          if (mcnt == 2'd3) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // sample capture
  always_ff @(posedge clk) begin
    if (sample_in.ready && sample_in.valid) begin
      dry_l   <= sample_in.in_left;
      dry_r   <= sample_in.in_right;
      wet_l   <= sample_in.wet_left;
      wet_r   <= sample_in.wet_right;
      tgt_wet <= sample_in.wet_target;
      tgt_dry <= sample_in.dry_target;
      start_r <= sample_in.block_start;
      snap_r  <= sample_in.snap;
    end
  end

  // gain state: snap / ramp restart / per-sample advance
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 2; k++) begin
        gain_now[k]       <= '0;
        gain_goal[k]      <= '0;
        gain_increment[k] <= '0;
        steps_left[k]     <= '0;
      end
    end else begin
      if (state == S_TAKE) begin
        if (snap_r) begin
          gain_goal[CH_WET]      <= tgt_wet;
          gain_goal[CH_DRY]      <= tgt_dry;
          gain_now[CH_WET]       <= {tgt_wet, {GAIN_SHIFT{1'b0}}};
          gain_now[CH_DRY]       <= {tgt_dry, {GAIN_SHIFT{1'b0}}};
          steps_left[CH_WET]     <= '0;
          steps_left[CH_DRY]     <= '0;
          gain_increment[CH_WET] <= '0;
          gain_increment[CH_DRY] <= '0;
        end else if (restart) begin
          gain_goal[ch]  <= tgt_sel;
          steps_left[ch] <= ramp_n;
        end
      end
      if ((state == S_DIV) && div_st.done) begin
        gain_increment[ch] <= quo_ext;
      end
      if (state == S_ADV) begin
        for (int k = 0; k < 2; k++) begin
          if (steps_left[k] == '0) begin
            gain_now[k] <= {gain_goal[k], {GAIN_SHIFT{1'b0}}};
          end else begin
            steps_left[k] <= steps_left[k] - 1'b1;
            // last step lands on the goal exactly
            if (steps_left[k] == STEP_W'(1)) begin
              gain_now[k] <= {gain_goal[k], {GAIN_SHIFT{1'b0}}};
            end else begin
              gain_now[k] <= gain_now[k] + gain_increment[k][GAIN_W-1:0];
            end
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if ((state == S_FIN) && out_free) begin
      out_vld <= 1'b1;
    end else if (mix_out.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FIN) && out_free) begin
      out_l <= round_sat(acc_left);
      out_r <= round_sat(acc_right);
    end
  end

  assign mix_out.valid     = out_vld;
  assign mix_out.out_left  = out_l;
  assign mix_out.out_right = out_r;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  `RWDM_ASSERT_IMPL(a_ready_idle, clk, rst, sample_in.ready, !div_st.busy && (mcnt == 2'd0 || state == S_IDLE), "input ready while divider busy")
  `RWDM_ASSERT_IMPL(a_done_in_div, clk, rst, div_st.done, state == S_DIV, "divider finished outside DIV")
  `RWDM_ASSERT_NEXT(a_div_exit, clk, rst, (state == S_DIV) && div_st.done, (state == S_TAKE) || (state == S_ADV), "bad exit from DIV")
  `RWDM_ASSERT_IMPL(a_wet_settled, clk, rst, (state == S_MUL) && (steps_left[CH_WET] == '0), (gain_now[CH_WET] == {gain_goal[CH_WET], 16'h0000}), "idle wet gain off goal")
  `RWDM_ASSERT_IMPL(a_dry_settled, clk, rst, (state == S_MUL) && (steps_left[CH_DRY] == '0), (gain_now[CH_DRY] == {gain_goal[CH_DRY], 16'h0000}), "idle dry gain off goal")

endmodule
`default_nettype wire

[rtl/core/rwdm_div.sv]
// Serial restoring divider: 32-bit magnitude by 14-bit ramp length, one bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module rwdm_div import rwdm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [QUO_W-1:0]  dividend,
  input  wire logic [STEP_W-1:0] divisor,
  output div_status_t            status,
  output logic [QUO_W-1:0]       quotient
);

  logic              busy;
  logic              done;
  logic [QCNT_W-1:0] cnt;
  logic [STEP_W-1:0] dvs;
  logic [STEP_W-1:0] rem;
  logic [QUO_W-1:0]  quo;
  logic [STEP_W:0]   rem_sh;
  logic [STEP_W:0]   rem_sub;
  logic              ge;

  // shift in next dividend bit, trial subtract
  assign rem_sh  = {rem, quo[QUO_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign ge      = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= QCNT_W'(QUO_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= ge ? rem_sub[STEP_W-1:0] : rem_sh[STEP_W-1:0];
      quo <= {quo[QUO_W-2:0], ge};
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = quo;

endmodule
`default_nettype wire

[rtl/core/rwdm_mac.sv]
// Shared multiply-accumulate: one registered product a cycle into left/right sums.
`timescale 1ns / 1ps
`default_nettype none
module rwdm_mac import rwdm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mac_ctrl_t         ctrl,
  input  wire sample_t           sample,
  input  wire logic [COEF_W-1:0] coef,
  output logic signed [ACC_W-1:0] acc_left,
  output logic signed [ACC_W-1:0] acc_right
);

  logic signed [PROD_W-1:0] prod;
  logic                     prod_vld;
  logic                     prod_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld  <= 1'b0;
      prod_side <= 1'b0;
    end else begin
      prod_vld  <= ctrl.issue;
      prod_side <= ctrl.side;
    end
  end

  // coefficient is unsigned: zero-extend before the signed multiply
  always_ff @(posedge clk) begin
    if (ctrl.issue) begin
      prod <= PROD_W'(sample) * PROD_W'($signed({1'b0, coef}));
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc_left  <= '0;
      acc_right <= '0;
    end else if (prod_vld) begin
      if (prod_side) begin
        acc_right <= acc_right + ACC_W'(prod);
      end else begin
        acc_left  <= acc_left + ACC_W'(prod);
      end
    end
  end

endmodule
`default_nettype wire
